// ----- rtl/core/olt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table package
// Command and status codes, field widths and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int CMD_W = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRIOR  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic            load;
        logic            start_up;
        logic            start_down;
        logic            start_scan;
        logic            shift_step;
        logic            scan_step;
        logic            write_val;
        logic            cap_rdata;
        logic            res_load;
        logic [ST_W-1:0] res_status;
    } olt_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pos_ok_ins;
        logic             pos_ok_acc;
        logic             shift_done;
        logic             scan_hit;
        logic             scan_miss;
        logic             prior_avail;
        logic             next_avail;
    } olt_stat_t;

endpackage

// ----- rtl/core/olt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/olt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table controller
// State machine that sequences each command through the datapath and owns
// the input and result handshakes.
// ----------------------------------------------------------------------------
module olt_ctrl
    import olt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  olt_stat_t stat,
    output olt_ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_WRVAL    = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_NWAIT    = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [ST_W-1:0] status_reg, status_next;
    logic            m_valid_reg, m_valid_next;

    always_comb begin
        ctrl         = '0;
        state_next   = state_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (stat.cmd) inside
                    CMD_INSERT: begin
                        if (stat.full) begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end else if (!stat.pos_ok_ins) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_RESP;
                        end else begin
                            ctrl.start_up = 1'b1;
                            state_next    = S_SHIFT;
                        end
                    end
                    CMD_DELETE, CMD_GET: begin
                        if (!stat.pos_ok_acc) begin
                            status_next = ST_BAD_POS;
                            state_next  = S_RESP;
                        end else begin
                            ctrl.start_down = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                        ctrl.start_scan = 1'b1;
                        state_next      = S_SCAN;
                    end
                    default: begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                endcase
            end
            S_SHIFT: begin
                ctrl.shift_step = 1'b1;
                if (stat.shift_done) begin
                    if (stat.cmd == CMD_INSERT) begin
                        state_next = S_WRVAL;
                    end else begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                end
            end
            S_WRVAL: begin
                ctrl.write_val = 1'b1;
                status_next    = ST_OK;
                state_next     = S_RESP;
            end
            S_SCAN: begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_hit) begin
                    if (stat.cmd == CMD_LOCATE) begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end else if (stat.cmd == CMD_PRIOR) begin
                        status_next = stat.prior_avail ? ST_OK : ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end else if (stat.next_avail) begin
                        state_next = S_NWAIT;
                    end else begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end else if (stat.scan_miss) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
            end
            S_NWAIT: begin
                ctrl.cap_rdata = 1'b1;
                status_next    = ST_OK;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.res_load   = 1'b1;
                    ctrl.res_status = status_reg;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/olt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table datapath
// Entry memory, length register, walk counters and result registers. The
// walk moves entries one per cycle through the registered memory read.
// ----------------------------------------------------------------------------
module olt_datapath
    import olt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  olt_ctrl_t               ctrl,
    output olt_stat_t               stat,
    input  logic [CMD_W-1:0]        s_cmd,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic [ST_W-1:0]         m_status,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [POS_W-1:0]        m_result_position,
    output logic [POS_W-1:0]        m_list_length,
    output logic                    m_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CMD_W-1:0] cmd_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    left_reg;
    logic [CW-1:0]    tag_reg;
    logic             pend_reg;
    logic             first_reg;
    logic [VAL_W-1:0] prev_reg;
    logic [VAL_W-1:0] cap_reg;

    logic [ST_W-1:0]  status_reg;
    logic [VAL_W-1:0] rval_reg;
    logic [POS_W-1:0] rpos_reg;
    logic [POS_W-1:0] len_reg;
    logic             empty_reg;

    logic [XW-1:0]    pos_x, cnt_x, tag_x, pos_m1, left_x, rpos_x, len_x;
    logic             up_mode, shift_issue, scan_issue, hit, res_ok;
    logic [VAL_W-1:0] rval_next;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    olt_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb begin
        pos_x       = XW'(pos_reg);
        cnt_x       = XW'(count_reg);
        tag_x       = XW'(tag_reg);
        pos_m1      = pos_x - XW'(1);
        left_x      = cnt_x + XW'(1) - pos_x;
        rpos_x      = tag_x + XW'(1);
        up_mode     = (cmd_reg == CMD_INSERT);
        shift_issue = (left_reg != '0);
        scan_issue  = (idx_reg < count_reg);
        hit         = pend_reg && (ram_rdata == val_reg);

        stat.cmd         = cmd_reg;
        stat.full        = (count_reg == CW'(CAPACITY));
        stat.pos_ok_ins  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
        stat.pos_ok_acc  = (pos_x != '0) && (pos_x <= cnt_x);
        stat.shift_done  = !shift_issue && !pend_reg;
        stat.scan_hit    = hit;
        stat.scan_miss   = !pend_reg && !scan_issue;
        stat.prior_avail = (tag_reg != '0);
        stat.next_avail  = (rpos_x < cnt_x);

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        if (ctrl.shift_step && pend_reg && !first_reg) begin
            ram_we = 1'b1;
            if (up_mode) begin
                ram_waddr = AW'(tag_x + XW'(1));
            end else begin
                ram_waddr = AW'(tag_x - XW'(1));
            end
        end
        if (ctrl.write_val) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(pos_m1);
            ram_wdata = val_reg;
        end

        res_ok     = ctrl.res_load && (ctrl.res_status == ST_OK);
        count_next = count_reg;
        if (res_ok) begin
            case (cmd_reg)
                CMD_CLEAR:  count_next = '0;
                CMD_INSERT: count_next = count_reg + CW'(1);
                CMD_DELETE: count_next = count_reg - CW'(1);
                default:    count_next = count_reg;
            endcase
        end
        len_x = XW'(count_next);

        rval_next = '0;
        if (ctrl.res_status == ST_OK) begin
            case (cmd_reg) inside
                CMD_DELETE, CMD_GET, CMD_PRIOR, CMD_NEXT: rval_next = cap_reg;
                default:                                  rval_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (ctrl.load) begin
                cmd_reg <= s_cmd;
                pos_reg <= s_position;
                val_reg <= s_value;
            end
            if (ctrl.start_up) begin
                idx_reg   <= count_reg - CW'(1);
                left_reg  <= CW'(left_x);
                pend_reg  <= 1'b0;
                first_reg <= 1'b0;
            end
            if (ctrl.start_down) begin
                idx_reg   <= CW'(pos_m1);
                left_reg  <= (cmd_reg == CMD_DELETE) ? CW'(left_x) : CW'(1);
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
            end
            if (ctrl.start_scan) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (ctrl.shift_step) begin
                if (shift_issue) begin
                    idx_reg  <= up_mode ? idx_reg - CW'(1) : idx_reg + CW'(1);
                    left_reg <= left_reg - CW'(1);
                    tag_reg  <= idx_reg;
                end
                pend_reg <= shift_issue;
                if (pend_reg && first_reg) begin
                    cap_reg   <= ram_rdata;
                    first_reg <= 1'b0;
                end
            end
            if (ctrl.scan_step) begin
                if (hit) begin
                    cap_reg <= prev_reg;
                end else begin
                    if (scan_issue) begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    pend_reg <= scan_issue;
                    tag_reg  <= idx_reg;
                    if (pend_reg) begin
                        prev_reg <= ram_rdata;
                    end
                end
            end
            if (ctrl.cap_rdata) begin
                cap_reg <= ram_rdata;
            end
            if (ctrl.res_load) begin
                status_reg <= ctrl.res_status;
                rval_reg   <= rval_next;
                rpos_reg   <= (res_ok && cmd_reg == CMD_LOCATE) ? rpos_x[POS_W-1:0] : '0;
                len_reg    <= len_x[POS_W-1:0];
                empty_reg  <= (count_next == '0);
            end
        end
    end

    assign m_status          = status_reg;
    assign m_result_value    = rval_reg;
    assign m_result_position = rpos_reg;
    assign m_list_length     = len_reg;
    assign m_is_empty        = empty_reg;

endmodule

// ----- rtl/core/ordered_list_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table
// Fixed-capacity ordered list of 32-bit values driven by one command per
// transaction, with a single result transaction per command.
// ----------------------------------------------------------------------------
// One command is processed at a time, and s_ready is high only while the
// block is idle. Clear, the undefined code and rejected commands go from
// dispatch straight to the response state, and get reads a single entry.
// Insert and delete move the entries from the given position to the end
// of the list one per cycle through the entry memory with its registered
// read, and insert then writes the new value at its position. Locate and
// prior scan from the head one entry per cycle and stop at the first
// match; next also captures the entry after the match, and a search
// without a match runs to the end of the list. The block returns to idle
// after each result before the next command can be taken. The result sits
// in an output register, so the next command is accepted once the previous
// result has been loaded into it, whether or not it has been taken yet; a
// new result then waits until the previous one has been taken.
module ordered_list_table
    import olt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CMD_W-1:0]        s_cmd,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ST_W-1:0]         m_status,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [POS_W-1:0]        m_result_position,
    output logic [POS_W-1:0]        m_list_length,
    output logic                    m_is_empty
);

    olt_ctrl_t ctrl;
    olt_stat_t stat;

    olt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    olt_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_status         (m_status),
        .m_result_value   (m_result_value),
        .m_result_position(m_result_position),
        .m_list_length    (m_list_length),
        .m_is_empty       (m_is_empty)
    );

endmodule

// ----- sim/ordered_list_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list table testbench
// Sends clear, insert, delete, get, locate, prior and next commands (and the
// undefined code), keeps a shadow copy of the list and checks every result
// transaction field by field. Directed cases come first, followed by random
// segments that fill, drain and search the list under varying back-pressure.
// ----------------------------------------------------------------------------
module ordered_list_table_tb;
    import olt_pkg::*;

    localparam int CAPACITY         = 128;
    localparam int RANDOM_ITEMS     = 1800;
    localparam int RUN_LIMIT_CYCLES = 1500000;

    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      wait_idle;
    } list_cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        length;
        logic                    empty;
    } list_reply_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_cmd = CMD_CLEAR;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [ST_W-1:0]         m_status;
    logic signed [VAL_W-1:0] m_result_value;
    logic [POS_W-1:0]        m_result_position;
    logic [POS_W-1:0]        m_list_length;
    logic                    m_is_empty;

    ordered_list_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_position(s_position),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_result_value(m_result_value),
        .m_result_position(m_result_position),
        .m_list_length(m_list_length),
        .m_is_empty(m_is_empty)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    list_cmd_t   cmd_backlog[$];
    list_reply_t awaited_replies[$];

    logic signed [VAL_W-1:0] shadow_mem [CAPACITY];
    int shadow_len = 0;
    int gen_len = 0;
    int total_items = 1;
    int n_accepted = 0;
    int n_checked = 0;
    int errors = 0;
    int cycle_count = 0;
    int peak_len = 0;
    int full_refusals = 0;
    int cmd_seen [8] = '{default: 0};

    logic signed [VAL_W-1:0] value_pool [8] = '{0, 1, -1, 2, -2, 1000, VAL_MIN, VAL_MAX};

    // Shadow list: applies one command and returns the reply it should produce.
    function automatic list_reply_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [VAL_W-1:0] val);
        list_reply_t r;
        int k;
        int hit;
        int p;
        r = '0;
        p = int'(pos);
        hit = shadow_len;
        for (k = shadow_len - 1; k >= 0; k--) begin
            if (shadow_mem[k] == val) hit = k;
        end
        case (cmd)
            CMD_CLEAR: shadow_len = 0;
            CMD_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_refusals++;
                end else if (p < 1 || p > shadow_len + 1) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (k = shadow_len; k >= p; k--) shadow_mem[k] = shadow_mem[k-1];
                    shadow_mem[p-1] = val;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > shadow_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.value = shadow_mem[p-1];
                    for (k = p - 1; k + 1 < shadow_len; k++) shadow_mem[k] = shadow_mem[k+1];
                    shadow_len--;
                end
            end
            CMD_GET: begin
                if (p < 1 || p > shadow_len) r.status = ST_BAD_POS;
                else r.value = shadow_mem[p-1];
            end
            CMD_LOCATE: begin
                if (hit >= shadow_len) r.status = ST_NOT_FOUND;
                else r.position = POS_W'(hit + 1);
            end
            CMD_PRIOR: begin
                if (hit >= shadow_len || hit == 0) r.status = ST_NOT_FOUND;
                else r.value = shadow_mem[hit-1];
            end
            CMD_NEXT: begin
                if (hit + 1 >= shadow_len) r.status = ST_NOT_FOUND;
                else r.value = shadow_mem[hit+1];
            end
            default: ;
        endcase
        if (shadow_len > peak_len) peak_len = shadow_len;
        r.length = POS_W'(shadow_len);
        r.empty  = (shadow_len == 0);
        return r;
    endfunction

    function automatic int idle_phase(input int done);
        int ph;
        ph = (done * 3) / total_items;
        return (ph > 2) ? 2 : ph;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] c, input int p,
                            input logic signed [VAL_W-1:0] v, input bit hold);
        list_cmd_t t;
        t.cmd = c;
        t.pos = p[POS_W-1:0];
        t.val = v;
        t.wait_idle = hold;
        cmd_backlog.push_back(t);
        case (c)
            CMD_CLEAR: gen_len = 0;
            CMD_INSERT: if (gen_len < CAPACITY && p >= 1 && p <= gen_len + 1) gen_len++;
            CMD_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(9) < 3) return $urandom;
        return value_pool[$urandom_range(7)];
    endfunction

    function automatic int pick_position(input logic [CMD_W-1:0] c);
        int top;
        top = (c == CMD_INSERT) ? gen_len + 1 : gen_len;
        if (top == 0 || $urandom_range(9) == 0) return $urandom_range(255);
        case ($urandom_range(4))
            0: return 1;
            1: return top;
            default: return $urandom_range(top, 1);
        endcase
    endfunction

    task automatic add_random_cmd(input int ins_pct, input int del_pct, input bit hold);
        int roll;
        logic [CMD_W-1:0] c;
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            c = CMD_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            c = CMD_DELETE;
        end else begin
            roll = $urandom_range(99);
            if (roll < 2) c = CMD_CLEAR;
            else if (roll < 4) c = CMD_NOP;
            else begin
                case (roll % 4)
                    0: c = CMD_GET;
                    1: c = CMD_LOCATE;
                    2: c = CMD_PRIOR;
                    default: c = CMD_NEXT;
                endcase
            end
        end
        push_cmd(c, pick_position(c), pick_value(), hold);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // Driver: predicts each accepted transaction and presents the next command.
    bit        took;
    int        in_flight;
    int        send_idle_pct;
    list_cmd_t staged;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_cmd <= CMD_CLEAR;
            s_position <= '0;
            s_value <= '0;
        end else begin
            took = s_valid && s_ready;
            if (took) begin
                awaited_replies.push_back(apply_list_command(s_cmd, s_position, s_value));
                cmd_seen[s_cmd]++;
                n_accepted <= n_accepted + 1;
            end
            if (!s_valid || took) begin
                in_flight = n_accepted - n_checked + (took ? 1 : 0);
                case (idle_phase(n_accepted))
                    0: send_idle_pct = 18;
                    1: send_idle_pct = 60;
                    default: send_idle_pct = 0;
                endcase
                if (cmd_backlog.size() != 0 && !(cmd_backlog[0].wait_idle && in_flight != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    staged = cmd_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= staged.cmd;
                    s_position <= staged.pos;
                    s_value <= staged.val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    list_reply_t due;
    int          recv_idle_pct;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: result transaction with no command outstanding", $time);
                    errors++;
                end else begin
                    due = awaited_replies.pop_front();
                    check_field("status", 32'(due.status), 32'(m_status));
                    check_field("result_value", due.value, m_result_value);
                    check_field("result_position", 32'(due.position), 32'(m_result_position));
                    check_field("list_length", 32'(due.length), 32'(m_list_length));
                    check_field("is_empty", 32'(due.empty), 32'(m_is_empty));
                end
                n_checked <= n_checked + 1;
            end
            case (idle_phase(n_checked))
                0: recv_idle_pct = 60;
                1: recv_idle_pct = 18;
                default: recv_idle_pct = 0;
            endcase
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT_CYCLES) begin
            $display("Run stopped after %0d cycles with %0d of %0d results checked.",
                     cycle_count, n_checked, total_items);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int  kind;
        int  seg_len;
        int  j;
        int  seg;
        int  target;
        bit  hold;

        // Directed cases on an empty list, then a short list with a duplicate.
        push_cmd(CMD_DELETE, 0, 0, 0);
        push_cmd(CMD_GET, 1, 0, 0);
        push_cmd(CMD_LOCATE, 0, 0, 0);
        push_cmd(CMD_PRIOR, 0, 0, 0);
        push_cmd(CMD_NEXT, 0, 0, 0);
        push_cmd(CMD_INSERT, 0, 7, 0);
        push_cmd(CMD_INSERT, 2, 7, 0);
        push_cmd(CMD_INSERT, 1, VAL_MIN, 0);
        push_cmd(CMD_INSERT, 2, VAL_MAX, 0);
        push_cmd(CMD_INSERT, 1, 0, 0);
        push_cmd(CMD_INSERT, 4, -1, 0);
        push_cmd(CMD_INSERT, 2, VAL_MAX, 0);
        push_cmd(CMD_GET, 5, 0, 0);
        push_cmd(CMD_GET, 6, 0, 0);
        push_cmd(CMD_LOCATE, 0, VAL_MAX, 0);
        push_cmd(CMD_LOCATE, 0, 12345, 0);
        push_cmd(CMD_PRIOR, 0, 0, 0);
        push_cmd(CMD_PRIOR, 0, VAL_MAX, 0);
        push_cmd(CMD_NEXT, 0, -1, 0);
        push_cmd(CMD_NEXT, 0, VAL_MAX, 0);
        push_cmd(CMD_NOP, 255, $urandom, 0);
        push_cmd(CMD_DELETE, 5, 0, 0);
        push_cmd(CMD_DELETE, 1, 0, 0);
        push_cmd(CMD_DELETE, 4, 0, 0);
        push_cmd(CMD_CLEAR, 0, 0, 0);

        // Random segments: the first fills the list, the rest fill, grow, shrink, mix or send raw codes.
        target = cmd_backlog.size() + RANDOM_ITEMS;
        seg = 0;
        while (cmd_backlog.size() < target) begin
            kind = (seg == 0) ? 0 : $urandom_range(9);
            hold = (seg == 0) || ($urandom_range(3) == 0);
            seg_len = $urandom_range(120, 20);
            seg++;
            if (kind == 0) begin
                push_cmd(CMD_INSERT, $urandom_range(gen_len + 1, 1), pick_value(), hold);
                while (gen_len < CAPACITY)
                    push_cmd(CMD_INSERT, $urandom_range(gen_len + 1, 1), pick_value(), 0);
                push_cmd(CMD_INSERT, 0, pick_value(), 0);
                push_cmd(CMD_INSERT, 255, pick_value(), 0);
                push_cmd(CMD_INSERT, CAPACITY, pick_value(), 0);
                push_cmd(CMD_GET, CAPACITY, 0, 0);
                push_cmd(CMD_LOCATE, 0, pick_value(), 0);
            end else if (kind == 9) begin
                for (j = 0; j < seg_len / 8; j++)
                    push_cmd(CMD_W'($urandom_range(7)), $urandom_range(255), $urandom,
                             j == 0 && hold);
            end else begin
                for (j = 0; j < seg_len; j++) begin
                    if (kind <= 3) add_random_cmd(70, 15, j == 0 && hold);
                    else if (kind <= 5) add_random_cmd(15, 65, j == 0 && hold);
                    else add_random_cmd(30, 30, j == 0 && hold);
                end
            end
        end
        total_items = cmd_backlog.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < total_items || n_checked < n_accepted) @(posedge aclk);
        repeat (CAPACITY + 16) @(posedge aclk);

        $display("Sent %0d commands: %0d insert, %0d delete, %0d get, %0d search,",
                 n_accepted, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_GET],
                 cmd_seen[CMD_LOCATE] + cmd_seen[CMD_PRIOR] + cmd_seen[CMD_NEXT]);
        $display("%0d clear and %0d undefined; longest list %0d entries, %0d inserts refused.",
                 cmd_seen[CMD_CLEAR], cmd_seen[CMD_NOP], peak_len, full_refusals);
        $display("%0d results compared.", n_checked);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/olt_pkg.sv
rtl/core/olt_ram.sv
rtl/core/olt_ctrl.sv
rtl/core/olt_datapath.sv
rtl/core/ordered_list_table.sv
sim/ordered_list_table_tb.sv
